// ===== src/tmt_pkg.sv =====
// TinyMT32 generator: shared types, constants and helper functions.
// Used by every module of the block and by the channel interfaces.
`timescale 1ns / 1ps

package tmt_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned StepWidth  = 5;
   localparam int unsigned MixRounds  = 7;
   localparam int unsigned WarmSteps  = 8;
   localparam int unsigned ShiftA     = 1;
   localparam int unsigned ShiftB     = 10;
   localparam int unsigned ShiftT     = 8;
   localparam int unsigned MixShift   = 30;

   localparam logic [31:0] GEN_MASK  = 32'h7fff_ffff;
   localparam logic [31:0] MIX_MULT  = 32'h6c07_8965;
   localparam logic [31:0] CERT_T    = 32'h0000_0054;
   localparam logic [31:0] CERT_I    = 32'h0000_0049;
   localparam logic [31:0] CERT_N    = 32'h0000_004e;
   localparam logic [31:0] CERT_Y    = 32'h0000_0059;

   typedef logic [3:0][WordWidth-1:0] gen_words_type;

   typedef enum logic [1:0] {
      OP_SEED = 2'd0,
      OP_LOAD = 2'd1,
      OP_NEXT = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_MAT1 = 2'd0,
      CSR_MAT2 = 2'd1,
      CSR_TMAT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MIX_MUL,
      ST_MIX_ACC,
      ST_WARM
   } seq_state_type;

   typedef struct packed {
      logic [WordWidth-1:0] mat1;
      logic [WordWidth-1:0] mat2;
      logic [WordWidth-1:0] tmat;
   } gen_params_type;

   // an all-zero state would never leave zero, so swap in "TINY"
   function automatic gen_words_type certify(gen_words_type w);
      gen_words_type r;
      r = w;
      if ((w[0] | w[1] | w[2] | w[3]) == '0) begin
         r[0] = CERT_T;
         r[1] = CERT_I;
         r[2] = CERT_N;
         r[3] = CERT_Y;
      end
      return r;
   endfunction

endpackage

// ===== src/tmt_channels.sv =====
// Valid/ready channel interfaces for the TinyMT32 generator:
// request, response and register write. Depends on tmt_pkg.
`timescale 1ns / 1ps

interface tmt_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    opcode;
   logic [tmt_pkg::WordWidth-1:0] seed_value;
   logic [tmt_pkg::WordWidth-1:0] load_word0;
   logic [tmt_pkg::WordWidth-1:0] load_word1;
   logic [tmt_pkg::WordWidth-1:0] load_word2;
   logic [tmt_pkg::WordWidth-1:0] load_word3;

   modport source (output valid, opcode, seed_value, load_word0, load_word1,
                   load_word2, load_word3, input ready);
   modport sink   (input valid, opcode, seed_value, load_word0, load_word1,
                   load_word2, load_word3, output ready);
endinterface

interface tmt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tmt_pkg::WordWidth-1:0] random_value;

   modport source (output valid, random_value, input ready);
   modport sink   (input valid, random_value, output ready);
endinterface

interface tmt_csr_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    index;
   logic [tmt_pkg::WordWidth-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/tmt_mix.sv =====
// Seed mixing multiplier: one round's product of the 0x6c078965 recurrence,
// registered. Depends on tmt_pkg.
`timescale 1ns / 1ps

module tmt_mix (
   input  logic                          clock,
   input  logic [tmt_pkg::WordWidth-1:0] prev_word,
   output logic [tmt_pkg::WordWidth-1:0] product_ff
);

   logic [tmt_pkg::WordWidth-1:0] folded;
   logic [tmt_pkg::WordWidth-1:0] product_in;

   // only the low word of the product is kept, so a 32x32 multiply will do
   always_comb begin
      folded     = prev_word ^ (prev_word >> tmt_pkg::MixShift);
      product_in = tmt_pkg::MIX_MULT * folded;
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

// ===== src/tmt_advance.sv =====
// State advance and output tempering, shared by warm-up and next requests.
// Depends on tmt_pkg.
`timescale 1ns / 1ps

module tmt_advance (
   input  tmt_pkg::gen_words_type         words,
   input  tmt_pkg::gen_params_type        params,
   output tmt_pkg::gen_words_type         next_words,
   output logic [tmt_pkg::WordWidth-1:0]  tempered
);

   logic [tmt_pkg::WordWidth-1:0] x;
   logic [tmt_pkg::WordWidth-1:0] y;
   logic [tmt_pkg::WordWidth-1:0] sum;

   always_comb begin
      x = (words[0] & tmt_pkg::GEN_MASK) ^ words[1] ^ words[2];
      x = x ^ (x << tmt_pkg::ShiftA);
      y = words[3] ^ (words[3] >> tmt_pkg::ShiftA) ^ x;
      next_words[0] = words[1];
      next_words[1] = words[2];
      next_words[2] = x ^ (y << tmt_pkg::ShiftB);
      next_words[3] = y;
      if (y[0]) begin
         next_words[1] = words[2] ^ params.mat1;
         next_words[2] = x ^ (y << tmt_pkg::ShiftB) ^ params.mat2;
      end

      // tempering works on the freshly advanced words
      sum      = next_words[0] + (next_words[2] >> tmt_pkg::ShiftT);
      tempered = next_words[3] ^ sum;
      if (sum[0]) begin
         tempered = tempered ^ params.tmat;
      end
   end

endmodule

// ===== src/tinymt32_generator.sv =====
// TinyMT32 generator top level: sequencer, state words, registers, response.
// Depends on tmt_pkg, tmt_channels, tmt_mix and tmt_advance.
`timescale 1ns / 1ps

// A next request (opcode 2) advances the 128-bit state and returns one tempered
// 32-bit word through the response register. A load (opcode 1) returns nothing;
// an all-zero load is replaced by the words "TINY". A seed (opcode 0) returns
// nothing and keeps the block busy after acceptance: seven mixing rounds,
// each through ST_MIX_MUL and ST_MIX_ACC and the single 32x32 multiplier,
// then eight advances through the shared advance unit. Opcode 3 is accepted
// and ignored. Requests are held off while a response is pending and not being
// taken. mat1, mat2 and tmat are written through the register port (always
// ready) by the user only while the block is idle; the block does not enforce it.

module tinymt32_generator (
   input  logic      clock,
   input  logic      reset,
   tmt_req_if.sink   req_bus,
   tmt_rsp_if.source rsp_bus,
   tmt_csr_if.sink   csr_bus
);

   tmt_pkg::seq_state_type        state_ff, state_in;
   tmt_pkg::gen_words_type        words_ff, words_in;
   logic [tmt_pkg::StepWidth-1:0] seed_step_ff, seed_step_in;
   tmt_pkg::gen_params_type       params_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tmt_pkg::WordWidth-1:0] random_value_ff, random_value_in;

   tmt_pkg::gen_words_type        adv_words;
   logic [tmt_pkg::WordWidth-1:0] adv_tempered;
   logic [tmt_pkg::WordWidth-1:0] mix_product;
   logic [1:0]                    prev_idx;
   logic [1:0]                    cur_idx;
   tmt_pkg::gen_words_type        mixed;
   logic                          req_fire;

   tmt_mix u_mix (
      .clock      (clock),
      .prev_word  (words_ff[prev_idx]),
      .product_ff (mix_product)
   );

   tmt_advance u_advance (
      .words      (words_ff),
      .params     (params_ff),
      .next_words (adv_words),
      .tempered   (adv_tempered)
   );

   assign cur_idx  = seed_step_ff[1:0];
   assign prev_idx = cur_idx - 2'd1;

   assign req_bus.ready = (state_ff == tmt_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.random_value = random_value_ff;
   assign csr_bus.ready        = 1'b1;

   always_comb begin
      state_in        = state_ff;
      words_in        = words_ff;
      seed_step_in    = seed_step_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      random_value_in = random_value_ff;
      mixed           = words_ff;
      mixed[cur_idx]  = words_ff[cur_idx] ^ (mix_product + tmt_pkg::WordWidth'(seed_step_ff));

      case (state_ff)
         tmt_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_bus.opcode)
                  tmt_pkg::OP_SEED: begin
                     words_in[0]  = req_bus.seed_value;
                     words_in[1]  = params_ff.mat1;
                     words_in[2]  = params_ff.mat2;
                     words_in[3]  = params_ff.tmat;
                     seed_step_in = tmt_pkg::StepWidth'(1);
                     state_in     = tmt_pkg::ST_MIX_MUL;
                  end
                  tmt_pkg::OP_LOAD: begin
                     words_in[0] = req_bus.load_word0;
                     words_in[1] = req_bus.load_word1;
                     words_in[2] = req_bus.load_word2;
                     words_in[3] = req_bus.load_word3;
                     words_in    = tmt_pkg::certify(words_in);
                  end
                  tmt_pkg::OP_NEXT: begin
                     words_in        = adv_words;
                     random_value_in = adv_tempered;
                     rsp_valid_in    = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         tmt_pkg::ST_MIX_MUL: begin
            state_in = tmt_pkg::ST_MIX_ACC;
         end
         tmt_pkg::ST_MIX_ACC: begin
            if (seed_step_ff == tmt_pkg::StepWidth'(tmt_pkg::MixRounds)) begin
               words_in     = tmt_pkg::certify(mixed);
               seed_step_in = '0;
               state_in     = tmt_pkg::ST_WARM;
            end else begin
               words_in     = mixed;
               seed_step_in = seed_step_ff + tmt_pkg::StepWidth'(1);
               state_in     = tmt_pkg::ST_MIX_MUL;
            end
         end
         tmt_pkg::ST_WARM: begin
            words_in = adv_words;
            if (seed_step_ff == tmt_pkg::StepWidth'(tmt_pkg::WarmSteps - 1)) begin
               seed_step_in = '0;
               state_in     = tmt_pkg::ST_IDLE;
            end else begin
               seed_step_in = seed_step_ff + tmt_pkg::StepWidth'(1);
            end
         end
         default: begin
            state_in = tmt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmt_pkg::ST_IDLE;
         seed_step_ff <= '0;
         rsp_valid_ff <= 1'b0;
         words_ff[0]  <= tmt_pkg::CERT_T;
         words_ff[1]  <= tmt_pkg::CERT_I;
         words_ff[2]  <= tmt_pkg::CERT_N;
         words_ff[3]  <= tmt_pkg::CERT_Y;
      end else begin
         state_ff     <= state_in;
         seed_step_ff <= seed_step_in;
         rsp_valid_ff <= rsp_valid_in;
         words_ff     <= words_in;
      end
      random_value_ff <= random_value_in;
   end

   // register writes; an index beyond the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         params_ff <= '0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            tmt_pkg::CSR_MAT1: params_ff.mat1 <= csr_bus.data;
            tmt_pkg::CSR_MAT2: params_ff.mat2 <= csr_bus.data;
            tmt_pkg::CSR_TMAT: params_ff.tmat <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

endmodule
